// ===== src/afhc_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio frame header checker package
// Shared word types, register indexes, profile and status codes.
// ----------------------------------------------------------------------------
package afhc_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned HLEN_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;

  localparam logic [1:0] PROF_NONE  = 2'd0;
  localparam logic [1:0] PROF_LONG  = 2'd1;
  localparam logic [1:0] PROF_SHORT = 2'd2;

  localparam logic [HLEN_W-1:0] LONG_HDR_LEN  = 5'd16;
  localparam logic [HLEN_W-1:0] SHORT_HDR_LEN = 5'd4;
  localparam logic [7:0]        HDR_VERSION   = 8'd2;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1275;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_HEADER  = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_PAYLOAD = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        out_last;
    logic [2:0]  status;
    logic [31:0] timestamp;
    logic [15:0] body_bytes;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic [1:0]  profile;
    logic [15:0] max_payload;
  } cfg_regs_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  function automatic logic [HLEN_W-1:0] hdr_len(input logic [1:0] profile);
    logic [HLEN_W-1:0] len;
    unique case (profile)
      PROF_NONE: len = '0;
      PROF_LONG: len = LONG_HDR_LEN;
      default:   len = SHORT_HDR_LEN;
    endcase
    return len;
  endfunction

endpackage

// ===== src/afhc_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One word moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface afhc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/afhc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the framing profile and the payload length limit.
// ----------------------------------------------------------------------------
module afhc_cfg_regs
  import afhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  afhc_stream_if.sink       cfg_ch,
  output cfg_regs_t         regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  cfg_word_t wr;

  assign wr           = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (wr.index)
        CFG_PROFILE:     regs_nxt.profile     = wr.wdata[1:0];
        CFG_MAX_PAYLOAD: regs_nxt.max_payload = wr.wdata[15:0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.profile     <= PROF_NONE;
      regs_r.max_payload <= MAX_PAYLOAD_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== src/afhc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one frame word and holds it until the checker takes it.
// ----------------------------------------------------------------------------
module afhc_in_stage
  import afhc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  afhc_stream_if.sink  in_ch,
  input  logic         take,
  output stage_t       stage
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  assign in_ch.ready = !valid_r || take;
  assign stage.valid = valid_r;
  assign stage.word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r <= in_ch.data;
    end
  end

endmodule

// ===== src/afhc_frame_check.sv =====
// ----------------------------------------------------------------------------
// Frame checker
// Tracks the frame state, checks header bytes, passes payload bytes on and
// closes each frame with a status into the result register.
// ----------------------------------------------------------------------------
module afhc_frame_check
  import afhc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_regs_t     regs,
  input  stage_t        stage,
  output logic          take,
  afhc_stream_if.source out_ch
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              bad_r, bad_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       time_r, time_nxt;
  logic              out_v_r, out_v_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic [HLEN_W-1:0] hlen;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  plen;
  logic [7:0]        b;
  logic              last;
  logic              rsvd;
  logic              is_hdr;
  logic              is_pay;
  logic              produce;
  logic              short_frame;
  status_t           status;

  assign b    = stage.word.in_byte;
  assign last = stage.word.in_last;
  assign hlen = hdr_len(regs.profile);
  assign rsvd = (regs.profile != PROF_NONE) && (regs.profile != PROF_LONG) &&
                (regs.profile != PROF_SHORT);

  assign is_hdr  = !rsvd && (cnt_r[CNT_W-1:HLEN_W] == '0) && (cnt_r[HLEN_W-1:0] < hlen);
  assign is_pay  = !rsvd && !is_hdr;
  assign produce = is_pay || last;
  assign take    = stage.valid && (!produce || !out_v_r || out_ch.ready);

  assign total = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    bad_nxt  = bad_r;
    len_nxt  = len_r;
    time_nxt = time_r;
    if (is_hdr) begin
      if (regs.profile == PROF_LONG) begin
        if (cnt_r[3:0] == 4'd1) begin
          if (b != HDR_VERSION) bad_nxt = 1'b1;
        end else if (cnt_r[3:0] < 4'd8) begin
          if (b != 8'd0) bad_nxt = 1'b1;
        end else if (cnt_r[3:0] < 4'd12) begin
          time_nxt = {time_r[23:0], b};
        end else begin
          len_nxt = {len_r[23:0], b};
        end
      end else begin
        if (cnt_r[3:0] < 4'd2) begin
          if (b != 8'd0) bad_nxt = 1'b1;
        end else begin
          len_nxt = {len_r[23:0], b};
        end
      end
    end
  end

  assign short_frame = rsvd ||
                       ((total[CNT_W-1:HLEN_W] == '0) && (total[HLEN_W-1:0] < hlen));
  assign plen = short_frame ? '0 : total - {{(CNT_W-HLEN_W){1'b0}}, hlen};

  always_comb begin
    priority if (short_frame) begin
      status = ST_SHORT;
    end else if (regs.profile != PROF_NONE && bad_nxt) begin
      status = ST_HEADER;
    end else if (regs.profile != PROF_NONE && len_nxt != plen) begin
      status = ST_LENGTH;
    end else if (plen == '0 || plen > {16'd0, regs.max_payload}) begin
      status = ST_PAYLOAD;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    out_word_nxt = '0;
    if (is_pay) begin
      out_word_nxt.out_byte  = b;
      out_word_nxt.out_valid = 1'b1;
    end
    if (last) begin
      out_word_nxt.out_last   = 1'b1;
      out_word_nxt.status     = status;
      out_word_nxt.timestamp  = (regs.profile == PROF_LONG) ? time_nxt : 32'd0;
      out_word_nxt.body_bytes = (plen[CNT_W-1:16] != '0) ? 16'hFFFF : plen[15:0];
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take && produce) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = last ? '0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      bad_r   <= 1'b0;
      len_r   <= '0;
      time_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
      if (take) begin
        bad_r  <= last ? 1'b0 : bad_nxt;
        len_r  <= last ? '0 : len_nxt;
        time_r <= last ? '0 : time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_word_r;

endmodule

// ===== src/audio_frame_header_checker_core.sv =====
// ----------------------------------------------------------------------------
// Audio frame header checker
// Checks framed audio bytes against the configured header profile, passes
// payload bytes on and closes each frame with a status word.
// ----------------------------------------------------------------------------
//   Channel  Direction  Word
//   in_ch    sink       in_byte, in_last
//   out_ch   source     out_byte, out_valid, out_last, status, timestamp,
//                       body_bytes
//   cfg_ch   sink       index, wdata (0 profile, 1 max_payload)
//
// One byte is taken every cycle while no result is stalled; a result word is
// offered behind the input register and the result register once its byte is
// accepted. rst_n is synchronous and clears the frame state, the registers and
// the handshakes. A stalled result holds the checker; a byte that gives no
// result still drains while the result waits.
// ----------------------------------------------------------------------------
module audio_frame_header_checker_core
  import afhc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  afhc_stream_if.sink   in_ch,
  afhc_stream_if.source out_ch,
  afhc_stream_if.sink   cfg_ch
);

  cfg_regs_t regs;
  stage_t    stage;
  logic      take;

  afhc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  afhc_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  afhc_frame_check u_frame_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .regs   (regs),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

  out_word_t ow;
  assign ow = out_ch.data;

  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (ow.out_valid || ow.out_last))
    else $error("result word carries neither a byte nor a frame close");

  a_mid_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !ow.out_last) |->
      (ow.status == ST_OK && ow.timestamp == 32'd0 && ow.body_bytes == 16'd0))
    else $error("frame summary fields set on a word that does not close the frame");

  a_no_hdr_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ow.out_last && regs.profile == PROF_NONE) |->
      (ow.status == ST_OK || ow.status == ST_PAYLOAD))
    else $error("header status reported for a profile without header");

endmodule
